// ===== rtl/cop0_timer_and_perf_counters_defines.svh =====
// ---------------------------------------------------------------------------
// cop0_timer_and_perf_counters_defines
// Assertion macros shared by the timer and performance counter RTL.
// ---------------------------------------------------------------------------
`ifndef COP0_TIMER_AND_PERF_COUNTERS_DEFINES_SVH
`define COP0_TIMER_AND_PERF_COUNTERS_DEFINES_SVH

`ifndef ASSERT_OFF
`define COP0TP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define COP0TP_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define COP0TP_ASSERT(label, clk, rst, prop, msg)
`define COP0TP_ASSERT_NORST(label, clk, prop, msg)
`endif

`endif

// ===== rtl/cop0tp_pkg.sv =====
// ---------------------------------------------------------------------------
// cop0tp_pkg
// Types, register indexes and decode helpers for the count/compare timer
// and the two performance counters.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cop0tp_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned EVT_W      = 5;
   localparam int unsigned ENABLE_BIT = 31;
   localparam int unsigned EVT_A_LSB  = 5;
   localparam int unsigned EVT_B_LSB  = 15;
   localparam int unsigned B_SHIFT    = 10;
   localparam int unsigned EXL_A_BIT  = 1;
   localparam int unsigned KERN_A_BIT = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERF_CONTROL  = 2'd0,
      CSR_COMPARE_VALUE = 2'd1
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_KERNEL     = 2'd0,
      MODE_SUPERVISOR = 2'd1,
      MODE_USER       = 2'd2
   } cpu_mode_type;

   typedef struct packed {
      logic [DATA_W-1:0] pulse_cycles;
      logic [MODE_W-1:0] cpu_mode;
      logic              in_exception;
   } tick_type;

   typedef struct packed {
      logic [DATA_W-1:0] perf_control;
      logic [DATA_W-1:0] compare_value;
   } cfg_type;

   typedef struct packed {
      logic              timer_pending;
      logic [DATA_W-1:0] timer_count;
      logic [DATA_W-1:0] perf_count_a;
      logic [DATA_W-1:0] perf_count_b;
   } state_type;

   // event codes 1..3 and 12..15 count
   function automatic logic event_countable(input logic [EVT_W-1:0] code);
      event_countable = ((code >= 5'd1) && (code <= 5'd3)) ||
                        ((code >= 5'd12) && (code <= 5'd15));
   endfunction

   // mode-enable group: bit 0 exception level, bits 1..3 kernel/super/user
   function automatic logic mode_match(input logic [3:0]        enables,
                                       input logic [MODE_W-1:0] mode,
                                       input logic              exl);
      logic hit;
      hit = exl & enables[0];
      case (mode)
         MODE_KERNEL:     hit = hit | enables[1];
         MODE_SUPERVISOR: hit = hit | enables[2];
         MODE_USER:       hit = hit | enables[3];
         default:         hit = hit;
      endcase
      mode_match = hit;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cop0tp_ifs.sv =====
// ---------------------------------------------------------------------------
// cop0tp_ifs
// Valid/ready channel interfaces: tick request, result response and
// register write port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cop0tp_req_if
   import cop0tp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] pulse_cycles;
   logic [MODE_W-1:0] cpu_mode;
   logic              in_exception;

   modport source (output valid, output pulse_cycles, output cpu_mode,
                   output in_exception, input ready);
   modport sink   (input valid, input pulse_cycles, input cpu_mode,
                   input in_exception, output ready);
endinterface

interface cop0tp_rsp_if
   import cop0tp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              timer_pending;
   logic [DATA_W-1:0] timer_count;
   logic [DATA_W-1:0] perf_count_a;
   logic [DATA_W-1:0] perf_count_b;

   modport source (output valid, output timer_pending, output timer_count,
                   output perf_count_a, output perf_count_b, input ready);
   modport sink   (input valid, input timer_pending, input timer_count,
                   input perf_count_a, input perf_count_b, output ready);
endinterface

interface cop0tp_csr_if
   import cop0tp_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/cop0tp_tick_unit.sv =====
// ---------------------------------------------------------------------------
// cop0tp_tick_unit
// Next-state logic for one tick: compare crossing, count advance and
// gated performance counter advance.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cop0tp_tick_unit
   import cop0tp_pkg::*;
(
   input  tick_type  tick,
   input  cfg_type   cfg,
   input  state_type cur,
   output state_type nxt
);

   logic [DATA_W-1:0] sum;
   logic              crossed;
   logic              enable;
   logic              count_a;
   logic              count_b;

   always_comb begin
      sum     = cur.timer_count + tick.pulse_cycles;
      crossed = (sum >= cfg.compare_value) && (cur.timer_count < cfg.compare_value);
      enable  = cfg.perf_control[ENABLE_BIT];

      count_a = enable &&
         mode_match(cfg.perf_control[EXL_A_BIT +: 4], tick.cpu_mode, tick.in_exception) &&
         event_countable(cfg.perf_control[EVT_A_LSB +: EVT_W]);
      count_b = enable &&
         mode_match(cfg.perf_control[EXL_A_BIT + B_SHIFT +: 4], tick.cpu_mode,
                    tick.in_exception) &&
         event_countable(cfg.perf_control[EVT_B_LSB +: EVT_W]);

      nxt.timer_pending = cur.timer_pending | crossed;
      nxt.timer_count   = sum;
      nxt.perf_count_a  = count_a ? (cur.perf_count_a + tick.pulse_cycles) : cur.perf_count_a;
      nxt.perf_count_b  = count_b ? (cur.perf_count_b + tick.pulse_cycles) : cur.perf_count_b;
   end

endmodule

`default_nettype wire

// ===== rtl/cop0_timer_and_perf_counters.sv =====
// Throughput: one tick per cycle while rsp_if is not stalled; an accepted
// tick is registered in the tick register, which feeds the next-state logic,
// whose result registers are the count and counter state itself.
// A stalled response holds the pipeline; the tick register still takes a
// transaction when empty or when the result register is free or being drained.
// Reset (synchronous, active high) clears all state and both config registers.
// ---------------------------------------------------------------------------
// cop0_timer_and_perf_counters
// Count/compare timer with sticky interrupt pending and two mode- and
// event-gated performance counters, one tick per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "cop0_timer_and_perf_counters_defines.svh"

module cop0_timer_and_perf_counters
   import cop0tp_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   cop0tp_req_if.sink   req_if,
   cop0tp_rsp_if.source rsp_if,
   cop0tp_csr_if.sink   csr_if
);

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   tick_type  tick_ff;
   logic      tick_valid_ff;
   logic      tick_valid_in;
   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      advance;
   logic      req_take;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign advance  = tick_valid_ff && out_free;
   assign req_take = req_if.valid && req_if.ready;

   assign req_if.ready = !tick_valid_ff || out_free;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.timer_pending = state_ff.timer_pending;
   assign rsp_if.timer_count   = state_ff.timer_count;
   assign rsp_if.perf_count_a  = state_ff.perf_count_a;
   assign rsp_if.perf_count_b  = state_ff.perf_count_b;

   state_type state_calc;

   cop0tp_tick_unit u_tick (
      .tick (tick_ff),
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .nxt  (state_calc)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_PERF_CONTROL:  cfg_in.perf_control  = csr_if.data;
            CSR_COMPARE_VALUE: cfg_in.compare_value = csr_if.data;
            default:           cfg_in = cfg_ff;
         endcase
      end

      tick_valid_in = req_take || (tick_valid_ff && !out_free);
      state_in      = advance ? state_calc : state_ff;
      rsp_valid_in  = advance || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '0;
         tick_valid_ff <= 1'b0;
         state_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         tick_valid_ff <= tick_valid_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         tick_ff.pulse_cycles <= req_if.pulse_cycles;
         tick_ff.cpu_mode     <= req_if.cpu_mode;
         tick_ff.in_exception <= req_if.in_exception;
      end
   end

   `COP0TP_ASSERT(a_pending_sticky, clock, reset, state_ff.timer_pending |=> state_ff.timer_pending, "timer pending dropped without reset")
   `COP0TP_ASSERT(a_state_hold, clock, reset, !advance |=> $stable(state_ff), "state changed without a tick advancing")
   `COP0TP_ASSERT(a_perf_gated, clock, reset, (advance && !cfg_ff.perf_control[ENABLE_BIT]) |=> ($stable(state_ff.perf_count_a) && $stable(state_ff.perf_count_b)), "performance counter moved while disabled")
   `COP0TP_ASSERT(a_rsp_follows, clock, reset, advance |=> rsp_valid_ff, "advanced tick produced no response")
   `COP0TP_ASSERT_NORST(a_reset_empty, clock, reset |=> (!tick_valid_ff && !rsp_valid_ff), "pipeline not empty after reset")

endmodule

`default_nettype wire
